// ===== design/rcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and request format for the RC channel scaler.
package rcs_pkg;

  localparam int CHAN_COUNT   = 6;
  localparam int CH_W         = 3;
  localparam int CH_SEL_W     = $clog2(CHAN_COUNT);
  localparam int PW_W         = 12;
  localparam int CAL_W        = 60;
  localparam int VAL_W        = 13;
  localparam int DIFF_W       = PW_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int MAG_W        = 2 * PW_W;
  localparam int FIX_W        = PW_W + 2;
  localparam int SUM_W        = FIX_W + 1;
  localparam int DIV_STEPS    = PW_W;
  localparam int Q_DEPTH      = 4;

  localparam logic [CAL_W-1:0] CAL_RESET = 60'd6938997621736;

  localparam logic [CH_W-1:0] CH_ROLL     = 3'd0;
  localparam logic [CH_W-1:0] CH_PITCH    = 3'd1;
  localparam logic [CH_W-1:0] CH_THROTTLE = 3'd2;
  localparam logic [CH_W-1:0] CH_YAW      = 3'd3;

  localparam logic [PW_W-1:0] THROTTLE_CUT = 12'd1070;

  localparam logic signed [FIX_W-1:0] YAW_DEAD   = -14'sd100;
  localparam logic signed [FIX_W-1:0] DEAD_POS   = 14'sd1;
  localparam logic signed [FIX_W-1:0] DEAD_NEG   = -14'sd1;
  localparam logic signed [SUM_W-1:0] SAT_MAX    = 15'sd4095;
  localparam logic signed [SUM_W-1:0] SAT_MIN    = -15'sd4096;

  // How a request is finished in the back end.
  typedef enum logic [1:0] {
    CLS_MAP,    // divide and add out_min
    CLS_EMPTY,  // empty input range: out_min
    CLS_ZERO,   // throttle below cut: zero, offset still applies
    CLS_NULL    // channel out of range: plain zero
  } cls_t;

  typedef struct packed {
    logic [CH_W-1:0]         ch;
    cls_t                    cls;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic [PW_W-1:0]         dd;
    logic signed [PW_W-1:0]  out_min;
    logic signed [PW_W-1:0]  off;
  } rcs_req_t;

endpackage

// ===== design/rcs_front.sv =====
`timescale 1ns / 1ps
// Front end: calibration registers, clamp, classify and multiply.
module rcs_front import rcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CH_W-1:0]  in_chan_index,
  input  logic [PW_W-1:0]  in_pulse_width,
  input  logic             cfg_we,
  input  logic [CH_W-1:0]  cfg_index,
  input  logic [CAL_W-1:0] cfg_wdata,
  output logic             req_valid,
  input  logic             req_ready,
  output rcs_req_t         req_data
);

  logic [CAL_W-1:0] cal_r [CHAN_COUNT];

  logic                   en;
  logic                   ch_ok;
  logic [CAL_W-1:0]       csel;
  logic [PW_W-1:0]        in_min, in_max, xc;
  logic                   empty;
  cls_t                   cls_nxt;
  logic [PW_W-1:0]        dx_nxt, dd_nxt;
  logic signed [DIFF_W-1:0] dr_nxt;

  logic                   f1_vld_r;
  logic [CH_W-1:0]        f1_ch_r;
  cls_t                   f1_cls_r;
  logic [PW_W-1:0]        f1_dx_r, f1_dd_r;
  logic signed [DIFF_W-1:0] f1_dr_r;
  logic signed [PW_W-1:0] f1_om_r, f1_off_r;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_abs;

  logic                   f2_vld_r;
  rcs_req_t               f2_req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAN_COUNT; i++) cal_r[i] <= CAL_RESET;
    end else if (cfg_we && (int'(cfg_index) < CHAN_COUNT)) begin
      cal_r[cfg_index[CH_SEL_W-1:0]] <= cfg_wdata;
    end
  end

  assign en       = !f2_vld_r || req_ready;
  assign in_ready = en;

  always_comb begin
    ch_ok  = int'(in_chan_index) < CHAN_COUNT;
    csel   = ch_ok ? cal_r[in_chan_index[CH_SEL_W-1:0]] : CAL_RESET;
    in_min = csel[11:0];
    in_max = csel[23:12];
    empty  = in_max <= in_min;
    if (in_pulse_width < in_min) begin
      xc = in_min;
    end else if (in_pulse_width > in_max) begin
      xc = in_max;
    end else begin
      xc = in_pulse_width;
    end
    dr_nxt = $signed({csel[47], csel[47:36]}) - $signed({csel[35], csel[35:24]});
    if (!ch_ok) begin
      cls_nxt = CLS_NULL;
    end else if (in_chan_index == CH_THROTTLE && in_pulse_width < THROTTLE_CUT) begin
      cls_nxt = CLS_ZERO;
    end else if (empty) begin
      cls_nxt = CLS_EMPTY;
    end else begin
      cls_nxt = CLS_MAP;
    end
    // keep the divider quiet on requests that skip the division
    if (cls_nxt == CLS_MAP) begin
      dx_nxt = xc - in_min;
      dd_nxt = in_max - in_min;
    end else begin
      dx_nxt = '0;
      dd_nxt = PW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= in_valid;
      f2_vld_r <= f1_vld_r;
    end
  end

  assign prod     = $signed({1'b0, f1_dx_r}) * f1_dr_r;
  assign prod_abs = prod[PROD_W-1] ? -prod : prod;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ch_r          <= in_chan_index;
      f1_cls_r         <= cls_nxt;
      f1_dx_r          <= dx_nxt;
      f1_dd_r          <= dd_nxt;
      f1_dr_r          <= dr_nxt;
      f1_om_r          <= $signed(csel[35:24]);
      f1_off_r         <= $signed(csel[59:48]);
      f2_req_r.ch      <= f1_ch_r;
      f2_req_r.cls     <= f1_cls_r;
      f2_req_r.neg     <= prod[PROD_W-1];
      f2_req_r.mag     <= prod_abs[MAG_W-1:0];
      f2_req_r.dd      <= f1_dd_r;
      f2_req_r.out_min <= f1_om_r;
      f2_req_r.off     <= f1_off_r;
    end
  end

  assign req_valid = f2_vld_r;
  assign req_data  = f2_req_r;

  a_null_class: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (int'(in_chan_index) >= CHAN_COUNT)) |=> f1_cls_r == CLS_NULL)
    else $error("out-of-range channel not classified as null");

endmodule

// ===== design/rcs_queue.sv =====
`timescale 1ns / 1ps
// Short request queue between the front and back ends.
module rcs_queue import rcs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  rcs_req_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output rcs_req_t pop_data
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  rcs_req_t          mem_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              push, pop;

  assign push_ready = cnt_r != CNT_W'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count did not drop on pop");

endmodule

// ===== design/rcs_back.sv =====
`timescale 1ns / 1ps
// Back end: pipelined divider, channel fixes, offset and saturation.
module rcs_back import rcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  rcs_req_t                req_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CH_W-1:0]         out_chan,
  output logic signed [VAL_W-1:0] out_scaled_value
);

  typedef struct packed {
    logic [CH_W-1:0]        ch;
    cls_t                   cls;
    logic                   neg;
    logic [PW_W-1:0]        dd;
    logic signed [PW_W-1:0] out_min;
    logic signed [PW_W-1:0] off;
  } side_t;

  logic                 adv;
  logic [DIV_STEPS:0]   vld_r;
  side_t                side_r [DIV_STEPS+1];
  logic [PW_W-1:0]      rem_r  [DIV_STEPS+1];
  logic [PW_W-1:0]      low_r  [DIV_STEPS+1];
  logic [PW_W-1:0]      quo_r  [DIV_STEPS+1];

  logic [DIFF_W-1:0]    trial   [DIV_STEPS];
  logic [DIFF_W-1:0]    trial_d [DIV_STEPS];
  logic                 qbit    [DIV_STEPS];
  logic [PW_W-1:0]      rem_nxt [DIV_STEPS];

  side_t                    last;
  logic signed [FIX_W-1:0]  sq, om, mv;

  logic                     fix_vld_r;
  logic signed [FIX_W-1:0]  fix_v_r;
  logic                     fix_null_r;
  logic [CH_W-1:0]          fix_ch_r;
  logic signed [PW_W-1:0]   fix_off_r;

  logic signed [SUM_W-1:0]  sum;
  logic signed [VAL_W-1:0]  val_nxt;

  logic                     out_valid_r;
  logic [CH_W-1:0]          out_chan_r;
  logic signed [VAL_W-1:0]  out_val_r;

  // whole back end moves together; stall only on a held result
  assign adv       = !out_valid_r || out_ready;
  assign req_ready = adv;

  // one restoring quotient bit per stage
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k]   = {rem_r[k], low_r[k][PW_W-1]};
      trial_d[k] = trial[k] - {1'b0, side_r[k].dd};
      qbit[k]    = trial[k] >= {1'b0, side_r[k].dd};
      rem_nxt[k] = qbit[k] ? trial_d[k][PW_W-1:0] : trial[k][PW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      fix_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[DIV_STEPS-1:0], req_valid};
      fix_vld_r   <= vld_r[DIV_STEPS];
      out_valid_r <= fix_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].ch      <= req_data.ch;
      side_r[0].cls     <= req_data.cls;
      side_r[0].neg     <= req_data.neg;
      side_r[0].dd      <= req_data.dd;
      side_r[0].out_min <= req_data.out_min;
      side_r[0].off     <= req_data.off;
      rem_r[0]          <= req_data.mag[MAG_W-1:PW_W];
      low_r[0]          <= req_data.mag[PW_W-1:0];
      quo_r[0]          <= '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        side_r[k] <= side_r[k-1];
        rem_r[k]  <= rem_nxt[k-1];
        low_r[k]  <= {low_r[k-1][PW_W-2:0], 1'b0};
        quo_r[k]  <= {quo_r[k-1][PW_W-2:0], qbit[k-1]};
      end
    end
  end

  always_comb begin
    last = side_r[DIV_STEPS];
    sq   = last.neg ? -$signed({2'b00, quo_r[DIV_STEPS]})
                    : $signed({2'b00, quo_r[DIV_STEPS]});
    om   = FIX_W'(last.out_min);
    case (last.cls)
      CLS_MAP:   mv = sq + om;
      CLS_EMPTY: mv = om;
      default:   mv = '0;
    endcase
    if (last.ch == CH_YAW && mv == YAW_DEAD) begin
      mv = '0;
    end
    case (last.ch) inside
      CH_ROLL, CH_PITCH, CH_YAW: begin
        if (mv == DEAD_POS || mv == DEAD_NEG) begin
          mv = '0;
        end
      end
      default: ;
    endcase
    if (last.ch == CH_YAW) begin
      mv = -mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fix_v_r    <= mv;
      fix_null_r <= last.cls == CLS_NULL;
      fix_ch_r   <= last.ch;
      fix_off_r  <= last.off;
    end
  end

  always_comb begin
    sum = SUM_W'(fix_v_r) + SUM_W'(fix_off_r);
    if (fix_null_r) begin
      val_nxt = '0;
    end else if (sum > SAT_MAX) begin
      val_nxt = SAT_MAX[VAL_W-1:0];
    end else if (sum < SAT_MIN) begin
      val_nxt = SAT_MIN[VAL_W-1:0];
    end else begin
      val_nxt = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_chan_r <= fix_ch_r;
      out_val_r  <= val_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chan         = out_chan_r;
  assign out_scaled_value = out_val_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[DIV_STEPS] && side_r[DIV_STEPS].cls == CLS_MAP)
      |-> rem_r[DIV_STEPS] < side_r[DIV_STEPS].dd)
    else $error("divider remainder not below divisor");

endmodule

// ===== design/rc_channel_scaler_unit.sv =====
`timescale 1ns / 1ps
// RC channel scaler top level: front end, request queue and back end.
//
// Maps a receiver pulse width on one channel to a saturated 13-bit command using that
// channel's calibration register (input range, output range, offset), with the throttle
// cut below 1070 us and the roll, pitch and yaw dead-band and yaw inversion rules. The
// block takes one request per clock cycle while in_ready is high and returns one result
// per request, in order. A request passes through the clamp register, which loads at
// the accepting edge, then the multiply stage, the four-entry request queue, the
// divider input register, twelve stages of the restoring divider that produce one
// quotient bit each, one fix-up stage and the output register. Calibration writes
// take effect at once and are meant to be made while no request is in flight.
module rc_channel_scaler_unit import rcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CH_W-1:0]         in_chan_index,
  input  logic [PW_W-1:0]         in_pulse_width,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CH_W-1:0]         out_chan,
  output logic signed [VAL_W-1:0] out_scaled_value,
  input  logic                    cfg_we,
  input  logic [CH_W-1:0]         cfg_index,
  input  logic [CAL_W-1:0]        cfg_wdata
);

  logic     fq_valid, fq_ready;
  rcs_req_t fq_data;
  logic     qb_valid, qb_ready;
  rcs_req_t qb_data;

  rcs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_chan_index  (in_chan_index),
    .in_pulse_width (in_pulse_width),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .req_valid      (fq_valid),
    .req_ready      (fq_ready),
    .req_data       (fq_data)
  );

  rcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  rcs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (qb_valid),
    .req_ready        (qb_ready),
    .req_data         (qb_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chan         (out_chan),
    .out_scaled_value (out_scaled_value)
  );

endmodule
